// File: rtl/bqcnl_pkg.sv
// Shared types, constants and the coefficient table for the cascaded biquad filter.
`timescale 1ns / 1ps
`default_nettype none

package bqcnl_pkg;

  // Fixed-point formats.
  localparam int SigW         = 64;
  localparam int SigFrac      = 24;
  localparam int OutFrac      = 16;
  localparam int OutW         = 41;
  localparam int CoefW        = 32;
  localparam int CoefFracBits = 30;
  localparam int CoefShift    = 30 - CoefFracBits;
  localparam int TableRows    = 16;
  localparam int NumTerms     = 5;

  // Product terms of one section, in summation order.
  localparam logic [2:0] TermB0 = 3'd0;
  localparam logic [2:0] TermB1 = 3'd1;
  localparam logic [2:0] TermB2 = 3'd2;
  localparam logic [2:0] TermA1 = 3'd3;
  localparam logic [2:0] TermA2 = 3'd4;

  // History slots of one section.
  localparam logic [1:0] SlotX1 = 2'd0;
  localparam logic [1:0] SlotX2 = 2'd1;
  localparam logic [1:0] SlotY1 = 2'd2;
  localparam logic [1:0] SlotY2 = 2'd3;

  localparam logic signed [31:0] Unity = 32'sd1073741824;

  // Rows hold b0, b1, b2, a1, a2 in Q2.30; rows past the seventh pass the signal through.
  localparam logic signed [31:0] CoefQ30 [TableRows][NumTerms] = '{
    '{ 32'sd894952847,  -32'sd1448064125, 32'sd894952847,  -32'sd1448064125, 32'sd716163871 },
    '{ 32'sd1020901885, -32'sd1651853953, 32'sd1020901894, -32'sd1793881461, 32'sd960507698 },
    '{ 32'sd963463360,  -32'sd1558916460, 32'sd963463352,  -32'sd1383184776, 32'sd906467087 },
    '{ 32'sd270676,      32'sd541353,     32'sd270676,     -32'sd2083877232, 32'sd1011218114 },
    '{ 32'sd469919,      32'sd939838,     32'sd469919,     -32'sd2093367327, 32'sd1021505179 },
    '{ 32'sd779849,      32'sd1559698,    32'sd779849,     -32'sd2109859525, 32'sd1039237097 },
    '{ 32'sd1021587,     32'sd2043175,    32'sd1021587,    -32'sd2131236511, 32'sd1061581036 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 },
    '{ Unity, 32'sd0, 32'sd0, 32'sd0, 32'sd0 }
  };

  localparam logic signed [32:0] CoefHalf =
      (CoefShift > 0) ? (33'sd1 <<< (CoefShift - 1)) : 33'sd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_MLO,
    ST_MHI,
    ST_SCL,
    ST_ACC,
    ST_WB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_op;
    logic mul_lo;
    logic mul_hi;
    logic scale;
    logic accum;
    logic first;
    logic sub;
  } mac_ctrl_t;

  // Coefficient for a section and term, rounded half away from zero to CoefFracBits.
  function automatic logic signed [31:0] coef_at(input logic [3:0] row, input logic [2:0] col);
    logic signed [32:0] raw;
    logic signed [32:0] scaled;
    case (col)
      TermB0: raw = 33'(CoefQ30[row][0]);
      TermB1: raw = 33'(CoefQ30[row][1]);
      TermB2: raw = 33'(CoefQ30[row][2]);
      TermA1: raw = 33'(CoefQ30[row][3]);
      TermA2: raw = 33'(CoefQ30[row][4]);
      default: raw = '0;
    endcase
    if (CoefShift == 0) begin
      scaled = raw;
    end else if (!raw[32]) begin
      scaled = (raw + CoefHalf) >>> CoefShift;
    end else begin
      scaled = -((-raw + CoefHalf) >>> CoefShift);
    end
    return 32'(scaled);
  endfunction

endpackage

`default_nettype wire

// File: rtl/bqcnl_mac.sv
// Shared multiply, scale and saturating accumulate unit for the biquad sections.
`timescale 1ns / 1ps
`default_nettype none

module bqcnl_mac (
  input  logic                                    clk_i,
  input  bqcnl_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [bqcnl_pkg::SigW-1:0]       operand_i,
  input  logic signed [bqcnl_pkg::CoefW-1:0]      coef_i,
  output logic signed [bqcnl_pkg::SigW-1:0]       acc_o
);
  import bqcnl_pkg::*;

  localparam int         Up        = 32 - CoefFracBits;
  localparam logic [63:0] SigMax   = {1'b0, {63{1'b1}}};
  localparam logic [63:0] HiLimit  = SigMax >> Up;
  localparam logic [63:0] RoundHalf = 64'd1 << (CoefFracBits - 1);

  logic [63:0]        op_mag_q;
  logic [31:0]        cf_mag_q;
  logic               neg_q;
  logic [63:0]        plo_q;
  logic [63:0]        phi_q;
  logic signed [63:0] term_q;
  logic signed [63:0] acc_q;

  logic [63:0]        op_abs;
  logic [31:0]        cf_abs;
  logic [31:0]        mul_a;
  logic [63:0]        mul_p;
  logic [63:0]        sum_mag;
  logic [63:0]        mag;
  logic signed [63:0] term_d;
  logic signed [64:0] sum_acc;
  logic signed [63:0] sat_sum;
  logic signed [63:0] acc_d;

  always_comb begin
    op_abs = operand_i[63] ? (64'd0 - 64'(operand_i)) : 64'(operand_i);
    cf_abs = coef_i[31] ? (32'd0 - 32'(coef_i)) : 32'(coef_i);
  end

  // One 32x32 multiplier, used for the low and then the high half of the signal.
  assign mul_a = ctrl_i.mul_hi ? op_mag_q[63:32] : op_mag_q[31:0];
  assign mul_p = 64'(mul_a) * 64'(cf_mag_q);

  always_comb begin
    sum_mag = (phi_q << Up) + ((plo_q + RoundHalf) >> CoefFracBits);
    if (phi_q > HiLimit || sum_mag > SigMax) begin
      mag = SigMax;
    end else begin
      mag = sum_mag;
    end
    // Feedback terms are subtracted, which flips the product sign once more.
    if (neg_q ^ ctrl_i.sub) begin
      term_d = -$signed(mag);
    end else begin
      term_d = $signed(mag);
    end
  end

  always_comb begin
    sum_acc = {acc_q[63], acc_q} + {term_q[63], term_q};
    if (sum_acc[64] != sum_acc[63]) begin
      sat_sum = sum_acc[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_sum = sum_acc[63:0];
    end
    acc_d = ctrl_i.first ? term_q : sat_sum;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_op) begin
      op_mag_q <= op_abs;
      cf_mag_q <= cf_abs;
      neg_q    <= operand_i[63] ^ coef_i[31];
    end
    if (ctrl_i.mul_lo) begin
      plo_q <= mul_p;
    end
    if (ctrl_i.mul_hi) begin
      phi_q <= mul_p;
    end
    if (ctrl_i.scale) begin
      term_q <= term_d;
    end
    if (ctrl_i.accum) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: rtl/biquad_cascade_notch_lowpass_top.sv
// Top level: sequencer, section history memory and output register of the biquad cascade.
// The last section's ST_WB result is rounded into the output register once ST_DONE finds
// it free, and a new sample is taken only in ST_IDLE after that. Each of the five terms
// of a section passes in turn through the single shared 32x32 multiply-accumulate unit.
// The output register holds a finished beat while the next sample is taken.
// Reset clears the sequencer, the output valid and all history entries through valid bits.
`timescale 1ns / 1ps
`default_nettype none

module biquad_cascade_notch_lowpass_top #(
  parameter int STAGES      = 7,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bqcnl_pkg::OutW-1:0]   filtered_o
);
  import bqcnl_pkg::*;

  localparam int SecW      = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int HistDepth = 4 * STAGES;
  localparam int AddrW     = $clog2(HistDepth);
  localparam int RndShift  = SigFrac - OutFrac;
  localparam logic [SecW-1:0] SecLast = SecW'(STAGES - 1);

  state_e state_q, state_d;

  logic [SecW-1:0]    sec_q;
  logic [2:0]         term_q;
  logic signed [63:0] x_q;
  logic signed [63:0] hold_q;

  logic [63:0]          hist_mem [HistDepth];
  logic [HistDepth-1:0] vld_q;
  logic [63:0]          rd_data_q;
  logic                 rd_vld_q;

  logic                 out_valid_q;
  logic signed [OutW-1:0] filtered_q;

  mac_ctrl_t          ctrl;
  logic signed [63:0] acc;
  logic signed [63:0] hist_rd;
  logic signed [63:0] operand;
  logic signed [31:0] coef;

  logic               accept;
  logic               out_load;
  logic               rd_en;
  logic [1:0]         rd_slot;
  logic               wr_en;
  logic [1:0]         wr_slot;
  logic [63:0]        wr_data;
  logic               hold_en;
  logic [AddrW-1:0]   rd_addr;
  logic [AddrW-1:0]   wr_addr;

  logic signed [64:0]     rnd_sum;
  logic signed [OutW-1:0] out_sat;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: state_d = ST_MLO;
      ST_MLO: state_d = ST_MHI;
      ST_MHI: state_d = ST_SCL;
      ST_SCL: state_d = ST_ACC;
      ST_ACC: begin
        state_d = (term_q == TermA2) ? ST_WB : ST_ABS;
      end
      ST_WB: begin
        state_d = (sec_q == SecLast) ? ST_DONE : ST_ABS;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctrl       = '0;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_slot    = term_q[1:0];
    wr_en      = 1'b0;
    wr_slot    = SlotX1;
    wr_data    = x_q;
    hold_en    = 1'b0;
    ctrl.first = (term_q == TermB0);
    ctrl.sub   = (term_q == TermA1) || (term_q == TermA2);
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_ABS: begin
        ctrl.load_op = 1'b1;
        hold_en      = (term_q == TermB1) || (term_q == TermA1);
      end
      ST_MLO: ctrl.mul_lo = 1'b1;
      ST_MHI: begin
        ctrl.mul_hi = 1'b1;
        // Fetch the history operand of the next term; term k reads slot k.
        rd_en = (term_q != TermA2);
      end
      ST_SCL: begin
        ctrl.scale = 1'b1;
        case (term_q)
          TermB1: begin
            wr_en   = 1'b1;
            wr_slot = SlotX1;
            wr_data = x_q;
          end
          TermB2: begin
            wr_en   = 1'b1;
            wr_slot = SlotX2;
            wr_data = hold_q;
          end
          TermA2: begin
            wr_en   = 1'b1;
            wr_slot = SlotY2;
            wr_data = hold_q;
          end
          default: wr_en = 1'b0;
        endcase
      end
      ST_ACC: ctrl.accum = 1'b1;
      ST_WB: begin
        wr_en   = 1'b1;
        wr_slot = SlotY1;
        wr_data = acc;
      end
      ST_DONE: in_ready_o = 1'b0;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign rd_addr = AddrW'({sec_q, rd_slot});
  assign wr_addr = AddrW'({sec_q, wr_slot});

  // An entry never written since reset reads as zero.
  assign hist_rd = rd_vld_q ? $signed(rd_data_q) : 64'sd0;
  assign operand = (term_q == TermB0) ? x_q : hist_rd;
  assign coef    = coef_at(4'(sec_q), term_q);

  bqcnl_mac u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .operand_i (operand),
    .coef_i    (coef),
    .acc_o     (acc)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= '0;
      term_q      <= TermB0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        sec_q  <= '0;
        term_q <= TermB0;
      end
      if (state_q == ST_ACC) begin
        term_q <= (term_q == TermA2) ? TermB0 : term_q + 3'd1;
      end
      if (state_q == ST_WB && sec_q != SecLast) begin
        sec_q <= sec_q + SecW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Round to the output format and clamp to the 41-bit range.
  always_comb begin
    rnd_sum = {x_q[63], x_q} + 65'sd128;
    if (!rnd_sum[64] && (rnd_sum[63:OutW+RndShift-1] != '0)) begin
      out_sat = {1'b0, {(OutW-1){1'b1}}};
    end else if (rnd_sum[64] && (rnd_sum[63:OutW+RndShift-1] != '1)) begin
      out_sat = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      out_sat = rnd_sum[OutW+RndShift-1:RndShift];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= $signed(64'(sample_i) << SigFrac);
    end else if (state_q == ST_WB) begin
      x_q <= acc;
    end
    if (hold_en) begin
      hold_q <= hist_rd;
    end
    if (out_load) begin
      filtered_q <= out_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

endmodule

`default_nettype wire

// File: bench/biquad_cascade_checker.sv
// Checker for the biquad cascade: predicts each filtered beat and compares it with the output.
`timescale 1ns / 1ps

module biquad_cascade_checker #(
  parameter int STAGES      = 7,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [bqcnl_pkg::OutW-1:0] filtered_i,
  output int                                mismatches_o,
  output int                                results_owed_o
);

  import bqcnl_pkg::*;

  localparam logic signed [SigW-1:0] SigMax = {1'b0, {(SigW-1){1'b1}}};
  localparam logic signed [SigW-1:0] SigMin = {1'b1, {(SigW-1){1'b0}}};
  localparam logic [127:0]           ProdMax = 128'(SigMax);
  localparam logic signed [65:0]     OutHi = (66'sd1 <<< (OutW - 1)) - 66'sd1;
  localparam logic signed [65:0]     OutLo = -(66'sd1 <<< (OutW - 1));
  localparam logic signed [65:0]     OutHalf = 66'sd1 <<< (SigFrac - OutFrac - 1);

  // Index 0 is one sample back, index 1 two samples back.
  logic signed [SigW-1:0] x_hist [STAGES][2];
  logic signed [SigW-1:0] y_hist [STAGES][2];

  logic signed [OutW-1:0] filtered_expected [$];
  logic signed [OutW-1:0] want;
  int                     errors;

  function automatic logic signed [31:0] section_coef(input int row, input logic [2:0] term);
    logic signed [32:0] raw;
    logic signed [32:0] half;
    raw  = 33'(CoefQ30[row][term]);
    half = (33'sd1 <<< CoefShift) >>> 1;
    if (CoefShift == 0) begin
      return raw[31:0];
    end else if (!raw[32]) begin
      return 32'((raw + half) >>> CoefShift);
    end
    return 32'(-((-raw + half) >>> CoefShift));
  endfunction

  // Exact product rounded half away from zero, magnitude clamped to the signal range.
  function automatic logic signed [SigW-1:0] coef_product(input logic signed [31:0] coef,
                                                           input logic signed [SigW-1:0] sig);
    logic                   neg;
    logic signed [SigW-1:0] cw;
    logic [SigW-1:0]        cmag;
    logic [SigW-1:0]        smag;
    logic [127:0]           mag;
    neg  = coef[31] != sig[SigW-1];
    cw   = 64'(coef);
    cmag = cw[SigW-1] ? -cw : cw;
    smag = sig[SigW-1] ? -sig : sig;
    mag  = {64'd0, smag} * {64'd0, cmag};
    mag  = (mag + (128'd1 << (CoefFracBits - 1))) >> CoefFracBits;
    if (mag > ProdMax) begin
      mag = ProdMax;
    end
    return neg ? -$signed(mag[SigW-1:0]) : $signed(mag[SigW-1:0]);
  endfunction

  function automatic logic signed [SigW-1:0] add_clamped(input logic signed [SigW-1:0] a,
                                                          input logic signed [SigW-1:0] b);
    logic signed [SigW:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SigMax)) begin
      return SigMax;
    end else if (s < 65'(SigMin)) begin
      return SigMin;
    end
    return s[SigW-1:0];
  endfunction

  // Runs one sample through every section, advancing the history.
  function automatic logic signed [OutW-1:0] filter_sample(input logic [SAMPLE_BITS-1:0] raw);
    logic signed [SigW-1:0] sig;
    logic signed [SigW-1:0] acc;
    logic signed [65:0]     rounded;
    sig = {{(SigW-SAMPLE_BITS){1'b0}}, raw} << SigFrac;
    for (int s = 0; s < STAGES; s++) begin
      acc = coef_product(section_coef(s, TermB0), sig);
      acc = add_clamped(acc, coef_product(section_coef(s, TermB1), x_hist[s][0]));
      acc = add_clamped(acc, coef_product(section_coef(s, TermB2), x_hist[s][1]));
      acc = add_clamped(acc, -coef_product(section_coef(s, TermA1), y_hist[s][0]));
      acc = add_clamped(acc, -coef_product(section_coef(s, TermA2), y_hist[s][1]));
      x_hist[s][1] = x_hist[s][0];
      x_hist[s][0] = sig;
      y_hist[s][1] = y_hist[s][0];
      y_hist[s][0] = acc;
      sig = acc;
    end
    rounded = (66'(sig) + OutHalf) >>> (SigFrac - OutFrac);
    if (rounded > OutHi) begin
      rounded = OutHi;
    end else if (rounded < OutLo) begin
      rounded = OutLo;
    end
    return rounded[OutW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) begin
        x_hist[s] = '{default: '0};
        y_hist[s] = '{default: '0};
      end
      filtered_expected.delete();
      errors = 0;
      mismatches_o <= 0;
      results_owed_o <= 0;
    end else begin
      // The output side is handled first: a beat accepted now came from an earlier sample.
      if (out_valid_i && out_ready_i) begin
        if (filtered_expected.size() == 0) begin
          $error("filtered: expected no beat, got %0d", filtered_i);
          errors++;
        end else begin
          want = filtered_expected.pop_front();
          if (filtered_i !== want) begin
            $error("filtered: expected %0d, got %0d", want, filtered_i);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        filtered_expected.push_back(filter_sample(sample_i));
      end
      mismatches_o <= errors;
      results_owed_o <= filtered_expected.size();
    end
  end

endmodule

// File: bench/tb_biquad_cascade_notch_lowpass_top.sv
// Testbench top for the biquad cascade: clock, reset, sample stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_biquad_cascade_notch_lowpass_top;

  localparam int Stages      = 7;
  localparam int SampleBits  = 24;
  localparam int PhaseItems  = 116;
  localparam int HoldCycles  = 1500;
  localparam int TailCycles  = 400;
  localparam int QuietLimit  = 20000;
  localparam int MaxGap      = 220;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [SampleBits-1:0]             sample;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [bqcnl_pkg::OutW-1:0] filtered;

  int mismatches;
  int results_owed;
  int send_idle_pct;
  int stall_pct;
  int holds_asked;
  int holds_served;
  int quiet_cycles;

  logic [SampleBits-1:0] last_sample;

  biquad_cascade_notch_lowpass_top #(
    .STAGES      (Stages),
    .SAMPLE_BITS (SampleBits)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .filtered_o  (filtered)
  );

  biquad_cascade_checker #(
    .STAGES      (Stages),
    .SAMPLE_BITS (SampleBits)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .sample_i       (sample),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .filtered_i     (filtered),
    .mismatches_o   (mismatches),
    .results_owed_o (results_owed)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // Offers one sample beat, after a random gap when the sender is idling.
  task automatic send_sample(input logic [SampleBits-1:0] value);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, MaxGap) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // The owed count is registered in the checker, so it lags the last accepted beat.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Mix of full-range values, rail-to-rail jumps and slow drifts around the last sample.
  function automatic logic [SampleBits-1:0] next_sample(input logic [SampleBits-1:0] prev);
    int step;
    case ($urandom_range(0, 9))
      0, 1: begin
        return $urandom_range(0, 1) ? {SampleBits{1'b1}} : {SampleBits{1'b0}};
      end
      2, 3, 4: begin
        step = int'($urandom_range(0, 4000)) - 2000;
        return prev + SampleBits'(step);
      end
      default: begin
        return SampleBits'($urandom);
      end
    endcase
  endfunction

  task automatic run_phase(input int count, input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) begin
      last_sample = next_sample(last_sample);
      send_sample(last_sample);
    end
    drain_results();
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Ends the run if no beat moves on either channel for too long.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    sample = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    holds_asked = 0;
    holds_served = 0;
    last_sample = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: zero, full-scale steps, rail-to-rail toggling and bit patterns.
    send_sample('0);
    send_sample('0);
    repeat (4) send_sample({SampleBits{1'b1}});
    send_sample('0);
    send_sample('0);
    repeat (3) begin
      send_sample({SampleBits{1'b1}});
      send_sample('0);
    end
    send_sample(SampleBits'(24'h800000));
    send_sample(SampleBits'(24'h7FFFFF));
    send_sample(SampleBits'(24'h000001));
    send_sample(SampleBits'(24'hAAAAAA));
    send_sample(SampleBits'(24'h555555));
    send_sample({SampleBits{1'b1}});
    send_sample('0);
    drain_results();

    run_phase(PhaseItems, 0, 0);
    run_phase(PhaseItems, 70, 0);
    // The sender keeps offering beats through the hold-off so the block backs up.
    holds_asked++;
    run_phase(PhaseItems, 0, 70);
    run_phase(PhaseItems, 9, 9);
    run_phase(PhaseItems, 0, 0);

    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
